// ===== hdl/gas_sensor_ppm_linearizer_defines.svh =====
// ----------------------------------------------------------------------------
// Gas sensor ppm linearizer assertion macros
// Concurrent check macros for the file that carries assertions.
// ----------------------------------------------------------------------------
`ifndef GAS_SENSOR_PPM_LINEARIZER_DEFINES_SVH
`define GAS_SENSOR_PPM_LINEARIZER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication: whenever ante holds, cons holds too.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication check failed");

// Next-cycle implication: whenever ante holds, cons holds in the cycle after.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication check failed");

`else

`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== hdl/gspl_pkg.sv =====
// ----------------------------------------------------------------------------
// Gas sensor ppm linearizer package
// Widths, fixed-point constants, state types and unit status for the block.
// ----------------------------------------------------------------------------
package gspl_pkg;

  // Converter sample and resistance format.
  localparam int SAMPLE_BITS   = 12;
  localparam int FRACTION_BITS = 16;
  localparam int RES_W         = 32;
  localparam int PPM_W         = 16;
  localparam int S_TDATA_W     = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int M_TDATA_W     = PPM_W + 2 * RES_W;
  localparam int M_TUSER_W     = 2;

  localparam logic [SAMPLE_BITS-1:0] SAMPLE_FULL = '1;

  // Log2 unit: Q1.31 mantissa squared by a serial 8-bit digit multiplier.
  localparam int MANT_W   = 32;
  localparam int TOP_W    = $clog2(MANT_W);
  localparam int LOG_FRAC = 20;
  localparam int LOG_W    = TOP_W + LOG_FRAC;
  localparam int DIGIT_W  = 8;
  localparam int DIGITS   = MANT_W / DIGIT_W;
  localparam int DCNT_W   = $clog2(DIGITS);
  localparam int ITER_W   = $clog2(LOG_FRAC);
  localparam int NIB_W    = 4;

  // Scaling constants.
  localparam int CAL_NUM_W = 14;
  localparam int EXP_NUM_W = 12;
  localparam logic [CAL_NUM_W-1:0] CAL_NUM = CAL_NUM_W'(10000);
  localparam logic [EXP_NUM_W-1:0] EXP_NUM = EXP_NUM_W'(2074);
  localparam int CAL_DEN   = 52124;
  localparam int EXP_DEN   = 1000;
  localparam int LOG2_COEF = 9711765;

  // Serial divider.
  localparam int DIV_W     = RES_W + CAL_NUM_W;
  localparam int DVS_W     = 16;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  // Exponent product and log-domain target.
  localparam int MAG_W = LOG_W + 2;
  localparam int T_W   = MAG_W + 1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RS_DIV,
    ST_BASE,
    ST_CAL_DIV,
    ST_CHECK,
    ST_LOG_RS,
    ST_LOG_R0,
    ST_MAG_START,
    ST_MAG_DIV,
    ST_SEARCH,
    ST_SEARCH_WAIT,
    ST_OUT
  } lin_state_e;

  typedef enum logic [1:0] {
    LG_IDLE,
    LG_NORM,
    LG_SQUARE
  } log_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_status_t;

endpackage

// ===== hdl/gspl_div.sv =====
// ----------------------------------------------------------------------------
// Gas sensor ppm linearizer serial divider
// Restoring division, one quotient bit per cycle, shared by all divisions.
// ----------------------------------------------------------------------------
module gspl_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [gspl_pkg::DIV_W-1:0]   dividend_i,
  input  logic [gspl_pkg::DVS_W-1:0]   divisor_i,
  output gspl_pkg::unit_status_t       status_o,
  output logic [gspl_pkg::DIV_W-1:0]   quotient_o
);
  import gspl_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DVS_W-1:0]     rem_q, rem_d;
  logic [DVS_W-1:0]     dvs_q, dvs_d;
  logic [DIV_W-1:0]     quo_q, quo_d;
  logic [DVS_W:0]       trial;
  logic [DVS_W:0]       diff;
  logic                 fits;

  // The dividend shifts out of the top of quo_q while quotient bits enter below.
  assign trial = {rem_q, quo_q[DIV_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    if (start_i && !busy_q) begin
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      quo_d = {quo_q[DIV_W-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign quotient_o    = quo_q;

endmodule

// ===== hdl/gspl_log2.sv =====
// ----------------------------------------------------------------------------
// Gas sensor ppm linearizer log2 unit
// Fixed-point log2 by normalization and repeated squaring of the mantissa.
// ----------------------------------------------------------------------------
module gspl_log2 (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [gspl_pkg::MANT_W-1:0]  x_i,
  output gspl_pkg::unit_status_t       status_o,
  output logic [gspl_pkg::LOG_W-1:0]   log_o
);
  import gspl_pkg::*;

  log_state_e                state_q, state_d;
  logic                      done_q, done_d;
  logic [DCNT_W-1:0]         dcnt_q, dcnt_d;
  logic [ITER_W-1:0]         iter_q, iter_d;
  logic [MANT_W-1:0]         mcand_q, mcand_d;
  logic [MANT_W-1:0]         mplier_q, mplier_d;
  logic [MANT_W-1:0]         acc_q, acc_d;
  logic [TOP_W-1:0]          top_q, top_d;
  logic [LOG_FRAC-1:0]       frac_q, frac_d;
  logic [MANT_W+DIGIT_W-1:0] pp;
  logic [MANT_W+DIGIT_W-1:0] sum;
  logic [MANT_W:0]           sq;
  logic [MANT_W-1:0]         m_next;

  // One 8-bit digit of the multiplier per cycle, low digit first. The bits
  // shifted out of the accumulator are the final low product bits, so the
  // last step yields the exact product shifted right by 31.
  assign pp     = {{DIGIT_W{1'b0}}, mcand_q} * {{MANT_W{1'b0}}, mplier_q[DIGIT_W-1:0]};
  assign sum    = {{DIGIT_W{1'b0}}, acc_q} + pp;
  assign sq     = {sum[MANT_W+DIGIT_W-1:DIGIT_W], sum[DIGIT_W-1]};
  assign m_next = sq[MANT_W] ? sq[MANT_W:1] : sq[MANT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= LG_IDLE;
      done_q  <= 1'b0;
      dcnt_q  <= '0;
      iter_q  <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      dcnt_q  <= dcnt_d;
      iter_q  <= iter_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    acc_q    <= acc_d;
    top_q    <= top_d;
    frac_q   <= frac_d;
  end

  always_comb begin
    state_d  = state_q;
    done_d   = 1'b0;
    dcnt_d   = dcnt_q;
    iter_d   = iter_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    acc_d    = acc_q;
    top_d    = top_q;
    frac_d   = frac_q;
    unique case (state_q)
      LG_IDLE: begin
        if (start_i) begin
          frac_d = '0;
          if (x_i == '0) begin
            top_d  = '0;
            done_d = 1'b1;
          end else begin
            mcand_d = x_i;
            top_d   = TOP_W'(MANT_W - 1);
            state_d = LG_NORM;
          end
        end
      end
      LG_NORM: begin
        // Shift by a nibble while the top nibble is clear, then bit by bit.
        if (mcand_q[MANT_W-1]) begin
          mplier_d = mcand_q;
          acc_d    = '0;
          dcnt_d   = '0;
          iter_d   = '0;
          state_d  = LG_SQUARE;
        end else if (mcand_q[MANT_W-1 -: NIB_W] == '0) begin
          mcand_d = mcand_q << NIB_W;
          top_d   = top_q - TOP_W'(NIB_W);
        end else begin
          mcand_d = mcand_q << 1;
          top_d   = top_q - 1'b1;
        end
      end
      LG_SQUARE: begin
        acc_d    = sum[MANT_W+DIGIT_W-1:DIGIT_W];
        mplier_d = mplier_q >> DIGIT_W;
        dcnt_d   = dcnt_q + 1'b1;
        if (dcnt_q == DCNT_W'(DIGITS - 1)) begin
          frac_d   = {frac_q[LOG_FRAC-2:0], sq[MANT_W]};
          mcand_d  = m_next;
          mplier_d = m_next;
          acc_d    = '0;
          dcnt_d   = '0;
          iter_d   = iter_q + 1'b1;
          if (iter_q == ITER_W'(LOG_FRAC - 1)) begin
            state_d = LG_IDLE;
            done_d  = 1'b1;
          end
        end
      end
      default: begin
        state_d = LG_IDLE;
      end
    endcase
  end

  assign status_o.busy = state_q != LG_IDLE;
  assign status_o.done = done_q;
  assign log_o         = {top_q, frac_q};

endmodule

// ===== hdl/gas_sensor_ppm_linearizer.sv =====
// ----------------------------------------------------------------------------
// Gas sensor ppm linearizer
// Turns an averaged converter sample into sensor resistance and a power-law
// gas concentration in parts per million, with clean-air calibration.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Word contents (lowest bit first)
//  --------  ---------  -------------------------------------------------------
//  s_axis    in         tdata: sample[11:0], zero pad to 16 bits
//  m_axis    out        tdata: ppm, sensor_resistance, base_resistance;
//                       tuser: save_request, no_signal
//  cfg       in         data: saved_resistance (Q16.16 megaohms)
//
//  One sample is in flight at a time; a word is taken only in the idle state.
//  Each item takes a pass of the bit-serial divider for the sensor resistance,
//  one more when calibration runs and one for exponent scaling, plus two to
//  eighteen log2 evaluations by the 8-bit digit squarer in the log unit (20
//  squarings of 4 digits each). A full-scale sample or a zero base resistance
//  skips the log work; a zero sample skips only the first pass.
//  Reset clears the stored base resistance and the saved value; no sweep.
//  The result register lets the next sample start while a word waits on m_axis.
//
`include "gas_sensor_ppm_linearizer_defines.svh"

module gas_sensor_ppm_linearizer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Sample in: tdata = sample[11:0], zero pad above.
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [gspl_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // Result out: tdata = ppm[15:0], sensor_resistance[47:16],
  // base_resistance[79:48].
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [gspl_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  // tuser = save_request[0], no_signal[1].
  output logic [gspl_pkg::M_TUSER_W-1:0]  m_axis_tuser,
  // Saved clean-air resistance write channel.
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [gspl_pkg::RES_W-1:0]      cfg_data_i
);
  import gspl_pkg::*;

  lin_state_e state_q, state_d;

  // Persistent state: saved value from the store and the base resistance.
  logic [RES_W-1:0] saved_q, saved_d;
  logic [RES_W-1:0] car_q, car_d;

  // Per-item working registers.
  logic [RES_W-1:0]      rs_q, rs_d;
  logic                  nosig_q, nosig_d;
  logic                  save_q, save_d;
  logic [LOG_W-1:0]      lrs_q, lrs_d;
  logic [LOG_W-1:0]      absd_q, absd_d;
  logic                  neg_q, neg_d;
  logic signed [T_W-1:0] t_q, t_d;
  logic [PPM_W-1:0]      lo_q, lo_d;
  logic [PPM_W-1:0]      hi_q, hi_d;
  logic [PPM_W-1:0]      mid_q, mid_d;
  logic [PPM_W-1:0]      ppm_q, ppm_d;

  // Result register facing m_axis.
  logic                  m_valid_q, m_valid_d;
  logic [M_TDATA_W-1:0]  m_data_q, m_data_d;
  logic [M_TUSER_W-1:0]  m_user_q, m_user_d;

  // Shared units.
  logic                  div_start;
  logic [DIV_W-1:0]      div_dividend;
  logic [DVS_W-1:0]      div_divisor;
  logic [DIV_W-1:0]      div_quo;
  unit_status_t          div_status;
  logic                  log_start;
  logic [MANT_W-1:0]     log_x;
  logic [LOG_W-1:0]      log_val;
  unit_status_t          log_status;

  logic                      in_accept;
  logic [SAMPLE_BITS-1:0]    sample;
  logic [SAMPLE_BITS-1:0]    span;
  logic [DIV_W-1:0]          rs_num;
  logic [DIV_W-1:0]          cal_prod;
  logic [LOG_W+EXP_NUM_W-1:0] mag_prod;
  logic [RES_W-1:0]          rs_sat;
  logic signed [LOG_W:0]     dlog;
  logic signed [LOG_W:0]     dlog_neg;
  logic signed [T_W-1:0]     coef_t;
  logic signed [T_W-1:0]     mag_t;
  logic signed [T_W-1:0]     t_calc;
  logic signed [T_W-1:0]     log_val_t;
  logic [PPM_W:0]            mid_sum;
  logic                      out_rs_ones;

  gspl_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .status_o   (div_status),
    .quotient_o (div_quo)
  );

  gspl_log2 u_log2 (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (log_start),
    .x_i      (log_x),
    .status_o (log_status),
    .log_o    (log_val)
  );

  assign s_axis_tready = state_q == ST_IDLE;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  assign sample = s_axis_tdata[SAMPLE_BITS-1:0];
  assign span   = SAMPLE_FULL - sample;
  // 2*(full - s) scaled to the resistance fraction.
  assign rs_num = DIV_W'({span, 1'b0}) << FRACTION_BITS;

  // Constant multiplies that feed the divider from registered operands.
  assign cal_prod = {{CAL_NUM_W{1'b0}}, rs_q} * {{RES_W{1'b0}}, CAL_NUM};
  assign mag_prod = {{EXP_NUM_W{1'b0}}, absd_q} * {{LOG_W{1'b0}}, EXP_NUM};

  // A quotient wider than the resistance field saturates to all ones.
  assign rs_sat = (div_quo[DIV_W-1:RES_W] != '0) ? '1 : div_quo[RES_W-1:0];

  // Log-domain difference of sensor and base resistance.
  assign dlog     = $signed({1'b0, lrs_q}) - $signed({1'b0, log_val});
  assign dlog_neg = -dlog;

  // Target log2(ppm) = log2(613.9) - 2.074 * (log2 RS - log2 R0).
  assign coef_t = $signed(T_W'(LOG2_COEF));
  assign mag_t  = $signed({1'b0, div_quo[MAG_W-1:0]});
  assign t_calc = neg_q ? (coef_t + mag_t) : (coef_t - mag_t);

  assign log_val_t = $signed({{(T_W - LOG_W){1'b0}}, log_val});
  assign mid_sum   = {1'b0, lo_q} + {1'b0, hi_q} + 1'b1;

  always_comb begin
    state_d   = state_q;
    saved_d   = saved_q;
    car_d     = car_q;
    rs_d      = rs_q;
    nosig_d   = nosig_q;
    save_d    = save_q;
    lrs_d     = lrs_q;
    absd_d    = absd_q;
    neg_d     = neg_q;
    t_d       = t_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    mid_d     = mid_q;
    ppm_d     = ppm_q;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;
    m_valid_d = m_valid_q && !m_axis_tready;

    div_start    = 1'b0;
    div_dividend = rs_num;
    div_divisor  = DVS_W'(sample);
    log_start    = 1'b0;
    log_x        = rs_q;

    if (cfg_valid_i) begin
      saved_d = cfg_data_i;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          save_d = 1'b0;
          if (sample == '0) begin
            // No signal: resistance pinned at all ones and used as is.
            rs_d    = '1;
            nosig_d = 1'b1;
            state_d = ST_BASE;
          end else begin
            nosig_d   = 1'b0;
            div_start = 1'b1;
            state_d   = ST_RS_DIV;
          end
        end
      end
      ST_RS_DIV: begin
        if (div_status.done) begin
          rs_d    = rs_sat;
          state_d = ST_BASE;
        end
      end
      ST_BASE: begin
        // Without a base resistance, restore the saved one or calibrate.
        if (car_q != '0) begin
          state_d = ST_CHECK;
        end else if (saved_q != '0) begin
          car_d   = saved_q;
          state_d = ST_CHECK;
        end else begin
          save_d       = 1'b1;
          div_start    = 1'b1;
          div_dividend = cal_prod;
          div_divisor  = DVS_W'(CAL_DEN);
          state_d      = ST_CAL_DIV;
        end
      end
      ST_CAL_DIV: begin
        if (div_status.done) begin
          car_d   = div_quo[RES_W-1:0];
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (rs_q == '0) begin
          // Zero resistance means an unbounded ratio.
          ppm_d   = '1;
          state_d = ST_OUT;
        end else if (car_q == '0) begin
          ppm_d   = '0;
          state_d = ST_OUT;
        end else begin
          log_start = 1'b1;
          log_x     = rs_q;
          state_d   = ST_LOG_RS;
        end
      end
      ST_LOG_RS: begin
        if (log_status.done) begin
          lrs_d     = log_val;
          log_start = 1'b1;
          log_x     = car_q;
          state_d   = ST_LOG_R0;
        end
      end
      ST_LOG_R0: begin
        if (log_status.done) begin
          neg_d   = dlog[LOG_W];
          absd_d  = dlog[LOG_W] ? dlog_neg[LOG_W-1:0] : dlog[LOG_W-1:0];
          state_d = ST_MAG_START;
        end
      end
      ST_MAG_START: begin
        div_start    = 1'b1;
        div_dividend = DIV_W'(mag_prod);
        div_divisor  = DVS_W'(EXP_DEN);
        state_d      = ST_MAG_DIV;
      end
      ST_MAG_DIV: begin
        if (div_status.done) begin
          t_d = t_calc;
          if (t_calc[T_W-1]) begin
            ppm_d   = '0;
            state_d = ST_OUT;
          end else begin
            lo_d    = PPM_W'(1);
            hi_d    = '1;
            state_d = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        // Binary search for the largest ppm whose log2 stays within target.
        if (lo_q == hi_q) begin
          ppm_d   = lo_q;
          state_d = ST_OUT;
        end else begin
          mid_d     = mid_sum[PPM_W:1];
          log_start = 1'b1;
          log_x     = MANT_W'(mid_sum[PPM_W:1]);
          state_d   = ST_SEARCH_WAIT;
        end
      end
      ST_SEARCH_WAIT: begin
        if (log_status.done) begin
          if (log_val_t <= t_q) begin
            lo_d = mid_q;
          end else begin
            hi_d = mid_q - 1'b1;
          end
          state_d = ST_SEARCH;
        end
      end
      ST_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = {car_q, rs_q, ppm_q};
          m_user_d  = {nosig_q, save_q};
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      saved_q   <= '0;
      car_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      saved_q   <= saved_d;
      car_q     <= car_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rs_q     <= rs_d;
    nosig_q  <= nosig_d;
    save_q   <= save_d;
    lrs_q    <= lrs_d;
    absd_q   <= absd_d;
    neg_q    <= neg_d;
    t_q      <= t_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    mid_q    <= mid_d;
    ppm_q    <= ppm_d;
    m_data_q <= m_data_d;
    m_user_q <= m_user_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  assign out_rs_ones = m_axis_tdata[PPM_W +: RES_W] == '1;

  // A taken sample closes the input until its result is loaded into the result register.
  `ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_accept, !s_axis_tready)
  // The sequencer never starts a shared unit that is still working.
  `ASSERT_IMPL(a_div_start_idle, clk_i, rst_ni, div_start, !div_status.busy)
  `ASSERT_IMPL(a_log_start_idle, clk_i, rst_ni, log_start, !log_status.busy)
  // A result flagged as no signal carries the saturated resistance.
  `ASSERT_IMPL(a_nosig_rs_ones, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[1], out_rs_ones)

endmodule

// ===== verif/gas_sensor_ppm_linearizer_tb.sv =====
// ----------------------------------------------------------------------------
// Gas sensor ppm linearizer testbench
// Streams converter samples into the linearizer. Each accepted word goes
// through a bit-exact integer model of the resistance, calibration and
// power-law math, and every result word is compared field by field with the
// oldest prediction. The random part runs under idle gaps on both sides, one
// long receiver hold-off and several saved-resistance settings.
// ----------------------------------------------------------------------------
module gas_sensor_ppm_linearizer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gspl_pkg::*;

  // Log-domain constants of the power law, Q.20.
  localparam longint PPM_LOG_COEF = 9711765;  // log2(613.9)
  localparam longint SLOPE_NUM    = 2074;
  localparam longint SLOPE_DEN    = 1000;
  localparam longint CAL_SCALE    = 10000;
  localparam longint CAL_DIV      = 52124;    // 5.2124 clean-air ratio
  localparam int     HOLD_CYCLES  = 8000;
  localparam int     PHASE_ITEMS  = 185;
  localparam int     MAX_PRINTS   = 30;

  typedef struct {
    logic [PPM_W-1:0] ppm;
    logic [RES_W-1:0] sensor_res;
    logic [RES_W-1:0] base_res;
    logic             save_req;
    logic             no_signal;
  } reading_t;

  logic                  clk_i;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  logic [M_TUSER_W-1:0]  m_axis_tuser;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [RES_W-1:0]      cfg_data_i    = '0;

  // Words waiting to be offered, and readings the block still owes us.
  logic [S_TDATA_W-1:0]  sample_words[$];
  reading_t              expected_readings[$];

  // Model state: what the block should hold.
  logic [RES_W-1:0]      model_saved_res = '0;
  logic [RES_W-1:0]      model_base_res  = '0;

  logic sample_taken = 1'b0;
  logic result_taken = 1'b0;
  int   gap_limit    = 7;
  int   stall_token  = 0;
  int   mismatches   = 0;

  gas_sensor_ppm_linearizer DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // log2 in Q.20: top set bit as integer part, fraction by repeated squaring
  // of the Q1.31 mantissa.
  function automatic longint unsigned log2_q20(logic [31:0] x);
    int          top;
    logic [63:0] mant;
    longint unsigned frac;
    if (x == 0) return 0;
    top = 31;
    while (!x[top]) top--;
    mant = 64'(x) << (31 - top);
    frac = 0;
    for (int i = 0; i < 20; i++) begin
      mant = (mant * mant) >> 31;
      frac = frac << 1;
      if (mant >= 64'h1_0000_0000) begin
        mant = mant >> 1;
        frac = frac | 1;
      end
    end
    return (longint'(top) << 20) | frac;
  endfunction

  // ppm = 613.9 * (rs/r0)^-2.074, evaluated in the log domain and inverted by
  // binary search over 1..65535.
  function automatic logic [PPM_W-1:0] concentration(logic [31:0] rs, logic [31:0] r0);
    longint diff;
    longint mag;
    longint target;
    int     lo;
    int     hi;
    int     mid;
    if (rs == 0) return '1;
    if (r0 == 0) return '0;
    diff   = longint'(log2_q20(rs)) - longint'(log2_q20(r0));
    mag    = (diff < 0) ? -diff : diff;
    mag    = mag * SLOPE_NUM / SLOPE_DEN;
    target = (diff >= 0) ? PPM_LOG_COEF - mag : PPM_LOG_COEF + mag;
    if (target < 0) return '0;
    lo = 1;
    hi = 65535;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (longint'(log2_q20(32'(mid))) <= target) lo = mid;
      else hi = mid - 1;
    end
    return PPM_W'(lo);
  endfunction

  // One sample through the model; updates the held clean-air resistance.
  function automatic reading_t linearize(logic [SAMPLE_BITS-1:0] s);
    reading_t    r;
    logic [63:0] quot;
    r.save_req  = 1'b0;
    r.no_signal = 1'b0;
    if (s == 0) begin
      r.sensor_res = '1;
      r.no_signal  = 1'b1;
    end else begin
      quot = (64'(2 * (SAMPLE_FULL - s)) << FRACTION_BITS) / 64'(s);
      r.sensor_res = (quot > 64'hFFFF_FFFF) ? '1 : quot[31:0];
    end
    if (model_base_res == 0) begin
      if (model_saved_res != 0) begin
        model_base_res = model_saved_res;
      end else begin
        model_base_res = 32'((64'(r.sensor_res) * CAL_SCALE) / CAL_DIV);
        r.save_req     = 1'b1;
      end
    end
    r.base_res = model_base_res;
    r.ppm      = concentration(r.sensor_res, model_base_res);
    return r;
  endfunction

  // Mix of extremes, flat draws and a log-spread draw so the resistance
  // covers many decades.
  function automatic logic [SAMPLE_BITS-1:0] draw_sample();
    int pick;
    int span;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      case ($urandom_range(0, 4))
        0: return '0;
        1: return SAMPLE_BITS'(1);
        2: return SAMPLE_BITS'(2);
        3: return SAMPLE_FULL - 1'b1;
        default: return SAMPLE_FULL;
      endcase
    end else if (pick < 60) begin
      return SAMPLE_BITS'($urandom);
    end
    span = $urandom_range(0, SAMPLE_BITS - 1);
    return SAMPLE_BITS'((32'd1 << span) | ($urandom & ((32'd1 << span) - 1)));
  endfunction

  task automatic note_mismatch(string what, longint unsigned got, longint unsigned want);
    if (mismatches < MAX_PRINTS)
      $display("%0t mismatch %0s: got %0h want %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Sample driver: one word at a time, random gap after each accepted word.
  int send_gap = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (sample_taken) send_gap = $urandom_range(0, gap_limit);
      if (!s_axis_tvalid || sample_taken) begin
        if (send_gap > 0) begin
          s_axis_tvalid <= 1'b0;
          send_gap--;
        end else if (sample_words.size() > 0) begin
          s_axis_tdata  <= sample_words.pop_front();
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result receiver: random wait after each word, plus a long hold-off each
  // time the stimulus bumps stall_token.
  int recv_gap   = 0;
  int hold_left  = 0;
  int stall_seen = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (stall_token != stall_seen) begin
        stall_seen = stall_token;
        hold_left  = HOLD_CYCLES;
      end
      if (result_taken) recv_gap = $urandom_range(0, gap_limit);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Monitor: config writes and accepted samples feed the model, result words
  // are checked against the oldest prediction.
  always @(posedge clk_i) begin
    reading_t want;
    if (rst_ni) begin
      sample_taken <= s_axis_tvalid && s_axis_tready;
      result_taken <= m_axis_tvalid && m_axis_tready;
      if (cfg_valid_i && cfg_ready_o) model_saved_res = cfg_data_i;
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_readings.size() == 0) begin
          note_mismatch("result word with nothing pending", m_axis_tdata[47:16], 0);
        end else begin
          want = expected_readings.pop_front();
          if (m_axis_tdata[15:0] !== want.ppm)
            note_mismatch("ppm", m_axis_tdata[15:0], want.ppm);
          if (m_axis_tdata[47:16] !== want.sensor_res)
            note_mismatch("sensor_resistance", m_axis_tdata[47:16], want.sensor_res);
          if (m_axis_tdata[79:48] !== want.base_res)
            note_mismatch("base_resistance", m_axis_tdata[79:48], want.base_res);
          if (m_axis_tuser[0] !== want.save_req)
            note_mismatch("save_request", m_axis_tuser[0], want.save_req);
          if (m_axis_tuser[1] !== want.no_signal)
            note_mismatch("no_signal", m_axis_tuser[1], want.no_signal);
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_readings.push_back(linearize(s_axis_tdata[SAMPLE_BITS-1:0]));
    end
  end

  task automatic write_saved(logic [RES_W-1:0] value);
    @(negedge clk_i);
    cfg_data_i  <= value;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Sender pause: nothing queued, nothing offered, nothing owed.
  task automatic wait_drained();
    @(posedge clk_i);
    while (sample_words.size() != 0 || s_axis_tvalid || expected_readings.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  initial begin
    int lock_mode;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Uncalibrated with nothing saved: a full-scale sample gives zero
    // resistance, so calibration lands on zero and repeats.
    write_saved('0);
    sample_words.push_back(S_TDATA_W'(SAMPLE_FULL));
    sample_words.push_back(S_TDATA_W'(SAMPLE_FULL));
    wait_drained();

    // The base resistance is fixed by the first step that leaves it nonzero;
    // the seed picks whether that is a restore or a calibration.
    lock_mode = $urandom_range(0, 7);
    case (lock_mode)
      0: begin
        write_saved(32'd1);
        sample_words.push_back(S_TDATA_W'(draw_sample()));
      end
      1: begin
        write_saved('1);
        sample_words.push_back(S_TDATA_W'(draw_sample()));
      end
      2: sample_words.push_back('0);  // calibrate on the saturated resistance
      3, 4: sample_words.push_back(S_TDATA_W'($urandom_range(1, SAMPLE_FULL - 1)));
      default: begin
        write_saved($urandom_range(32'h0000_4000, 32'h0100_0000));
        sample_words.push_back(S_TDATA_W'(draw_sample()));
      end
    endcase

    // Directed corners: zero and full scale, smallest samples, mid-scale and
    // alternating bit patterns, then words with the pad bits set.
    sample_words.push_back('0);
    sample_words.push_back(S_TDATA_W'(SAMPLE_FULL));
    sample_words.push_back(S_TDATA_W'(1));
    sample_words.push_back(S_TDATA_W'(2));
    sample_words.push_back(S_TDATA_W'(SAMPLE_FULL - 1));
    sample_words.push_back(S_TDATA_W'(12'h800));
    sample_words.push_back(S_TDATA_W'(12'h7FF));
    sample_words.push_back(S_TDATA_W'(12'h555));
    sample_words.push_back(S_TDATA_W'(12'hAAA));
    sample_words.push_back(S_TDATA_W'(12'h0FF));
    sample_words.push_back(S_TDATA_W'(12'hF00));
    sample_words.push_back(16'hF001);
    sample_words.push_back(16'hA000 | S_TDATA_W'(draw_sample()));
    wait_drained();

    for (int phase = 0; phase < 6; phase++) begin
      // Phase 1 runs with no idling on either side.
      gap_limit = (phase == 1) ? 0 : 7;
      case (phase)
        0: write_saved('1);
        1: write_saved('0);
        2: write_saved(32'd1);
        default: write_saved($urandom);
      endcase
      repeat (PHASE_ITEMS) sample_words.push_back(S_TDATA_W'(draw_sample()));
      // Hold the output long enough that the block backs up into its input.
      if (phase == 3) stall_token++;
      wait_drained();
    end

    repeat (2000) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/gspl_pkg.sv
hdl/gspl_div.sv
hdl/gspl_log2.sv
hdl/gas_sensor_ppm_linearizer.sv
verif/gas_sensor_ppm_linearizer_tb.sv
